[rtl/altl_pkg.sv]
package altl_pkg;

	// squared difference axis select
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	localparam logic [31:0] LEN_MAX    = 32'hFFFF_FFFF;
	localparam logic [16:0] FACTOR_ONE = 17'h1_0000;

	// controller to datapath
	typedef struct packed {
		logic  capture;
		logic  sq_en;
		axis_t sq_sel;
		logic  sqrt_start;
		logic  load_fin;
		logic  scan_step;
		logic  div_frac_start;
		logic  div_key_start;
		logic  frac_take;
		logic  frac_zero;
		logic  key_take;
		logic  past_end;
		logic  query_fin;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_query;
		logic idx_zero;
		logic over;
		logic sqrt_done;
		logic div_done;
		logic hit;
		logic last;
		logic need_div;
		logic out_free;
	} sts_t;

endpackage

[rtl/altl_isqrt.sv]
module altl_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic [31:0] root,
	output logic        done
);

	logic [63:0] v_q;
	logic [33:0] rem_q;
	logic [31:0] res_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [35:0] sh;
	logic [35:0] trial;
	logic        ge;
	logic [35:0] rem_n;

	// one result bit per cycle
	assign sh    = {rem_q, v_q[63:62]};
	assign trial = {2'b00, res_q, 2'b01};
	assign ge    = sh >= trial;
	assign rem_n = ge ? sh - trial : sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			rem_q <= '0;
			res_q <= '0;
		end else if (busy_q) begin
			v_q   <= {v_q[61:0], 2'b00};
			rem_q <= rem_n[33:0];
			res_q <= {res_q[30:0], ge};
		end
	end

	assign root = res_q;
	assign done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("root ready without a running pass");

endmodule

[rtl/altl_div.sv]
module altl_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic [47:0] quot,
	output logic        done
);

	logic [47:0] num_q;
	logic [31:0] den_q;
	logic [31:0] rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [32:0] sh;
	logic        ge;
	logic [32:0] rem_n;

	// restoring division, one quotient bit per cycle
	assign sh    = {rem_q, num_q[47]};
	assign ge    = sh >= {1'b0, den_q};
	assign rem_n = ge ? sh - {1'b0, den_q} : sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd47) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[46:0], ge};
			rem_q <= rem_n[31:0];
		end
	end

	assign quot = num_q;
	assign done = done_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("quotient ready without a running pass");

endmodule

[rtl/altl_dp.sv]
module altl_dp #(
	parameter int MAX_POINTS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  altl_pkg::cmd_t       cmd,
	output altl_pkg::sts_t       sts,
	input  logic                 point_count_we,
	input  logic [8:0]           point_count,
	input  logic                 req_type,
	input  logic [7:0]           point_index,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	input  logic [31:0]          query_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 resp_type,
	output logic [31:0]          point_length,
	output logic [31:0]          total_length,
	output logic [16:0]          factor,
	output logic                 length_saturated
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	// captured item
	logic [7:0]         idx_q;
	logic signed [31:0] x_q, y_q, z_q;
	logic [31:0]        ql_q;

	// persistent state
	logic signed [31:0] prev_x_q, prev_y_q, prev_z_q;
	logic [31:0]        run_q;
	logic               sat_q;
	logic [8:0]         pc_q;

	// length table
	logic [31:0] mem [MAX_POINTS];
	logic [31:0] rdata_q;
	logic [AW-1:0] scan_q;
	logic [31:0] ll_q;

	logic [65:0] acc_q;
	logic [16:0] frac_q;
	logic [16:0] factor_q;

	logic        out_valid_q;
	logic        resp_type_q;
	logic [31:0] point_length_q;
	logic [31:0] total_length_q;
	logic [16:0] factor_out_q;
	logic        sat_out_q;

	logic signed [31:0] ca, cb;
	logic signed [32:0] diff;
	logic [32:0]        mag;
	logic [65:0]        prod;

	logic [31:0] root;
	logic        sqrt_done;
	logic        over;
	logic [32:0] sum33;
	logic [31:0] new_run;
	logic        new_sat;

	logic [CW-1:0] count_c;
	logic [31:0]   ll_eff;
	logic [AW-1:0] left;
	logic          div_start;
	logic [47:0]   div_num;
	logic [31:0]   div_den;
	logic [47:0]   quot;
	logic          div_done;
	logic          out_free;

	// coordinate difference magnitude for the selected axis
	always_comb begin
		case (cmd.sq_sel)
			altl_pkg::AXIS_X: begin ca = x_q; cb = prev_x_q; end
			altl_pkg::AXIS_Y: begin ca = y_q; cb = prev_y_q; end
			altl_pkg::AXIS_Z: begin ca = z_q; cb = prev_z_q; end
			default:          begin ca = x_q; cb = prev_x_q; end
		endcase
	end

	assign diff = {ca[31], ca} - {cb[31], cb};
	assign mag  = diff[32] ? 33'(-diff) : 33'(diff);
	assign prod = mag * mag;

	altl_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (acc_q[63:0]),
		.root     (root),
		.done     (sqrt_done)
	);

	// next running length with saturation
	assign over  = |acc_q[65:64];
	assign sum33 = {1'b0, run_q} + {1'b0, root};

	always_comb begin
		if (idx_q == 8'd0) begin
			new_run = '0;
			new_sat = 1'b0;
		end else if (over || sum33[32]) begin
			new_run = altl_pkg::LEN_MAX;
			new_sat = 1'b1;
		end else begin
			new_run = sum33[31:0];
			new_sat = sat_q;
		end
	end

	// clamped point count
	always_comb begin
		if (pc_q == 9'd0)
			count_c = CW'(1);
		else if (32'(pc_q) > MAX_POINTS)
			count_c = CW'(MAX_POINTS);
		else
			count_c = CW'(pc_q);
	end

	// search and interpolation operands
	assign ll_eff = (scan_q == '0) ? rdata_q : ll_q;
	assign left   = (scan_q == '0) ? '0 : scan_q - AW'(1);

	assign div_start = cmd.div_frac_start | cmd.div_key_start;
	assign div_num   = cmd.div_key_start ? (48'(left) << 16) + 48'(frac_q)
	                                     : {ql_q - ll_eff, 16'h0000};
	assign div_den   = cmd.div_key_start ? 32'(count_c) : rdata_q - ll_eff;

	altl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quot   (quot),
		.done   (div_done)
	);

	assign out_free = !out_valid_q || out_ready;

	// status to controller
	always_comb begin
		sts.req_query = req_type;
		sts.idx_zero  = idx_q == 8'd0;
		sts.over      = over;
		sts.sqrt_done = sqrt_done;
		sts.div_done  = div_done;
		sts.hit       = rdata_q >= ql_q;
		sts.last      = (CW'(scan_q) + CW'(1)) == count_c;
		sts.need_div  = (rdata_q > ll_eff) && (ql_q > ll_eff);
		sts.out_free  = out_free;
	end

	// table memory
	always_ff @(posedge clk) begin
		if (cmd.load_fin && (32'(idx_q) < MAX_POINTS))
			mem[AW'(idx_q)] <= new_run;
		rdata_q <= mem[scan_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			prev_z_q    <= '0;
			run_q       <= '0;
			sat_q       <= 1'b0;
			pc_q        <= 9'd1;
			out_valid_q <= 1'b0;
		end else begin
			if (point_count_we)
				pc_q <= point_count;
			if (cmd.load_fin) begin
				prev_x_q <= x_q;
				prev_y_q <= y_q;
				prev_z_q <= z_q;
				run_q    <= new_run;
				sat_q    <= new_sat;
			end
			if (cmd.load_fin || cmd.query_fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			idx_q  <= point_index;
			x_q    <= pos_x;
			y_q    <= pos_y;
			z_q    <= pos_z;
			ql_q   <= query_length;
			scan_q <= '0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + AW'(1);
			ll_q   <= rdata_q;
		end
		if (cmd.sq_en)
			acc_q <= (cmd.sq_sel == altl_pkg::AXIS_X) ? prod : acc_q + prod;
		if (cmd.frac_zero)
			frac_q <= '0;
		else if (cmd.frac_take)
			frac_q <= (quot > 48'(altl_pkg::FACTOR_ONE)) ? altl_pkg::FACTOR_ONE
			                                             : quot[16:0];
		if (cmd.past_end)
			factor_q <= altl_pkg::FACTOR_ONE;
		else if (cmd.key_take)
			factor_q <= quot[16:0];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_fin) begin
			resp_type_q    <= 1'b0;
			point_length_q <= new_run;
			total_length_q <= new_run;
			factor_out_q   <= '0;
			sat_out_q      <= new_sat;
		end else if (cmd.query_fin) begin
			resp_type_q    <= 1'b1;
			point_length_q <= '0;
			total_length_q <= run_q;
			factor_out_q   <= factor_q;
			sat_out_q      <= sat_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign resp_type        = resp_type_q;
	assign point_length     = point_length_q;
	assign total_length     = total_length_q;
	assign factor           = factor_out_q;
	assign length_saturated = sat_out_q;

	a_fin_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_fin || cmd.query_fin) |-> out_free)
		else $error("result written over a pending beat");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> run_q == altl_pkg::LEN_MAX)
		else $error("saturated flag without maximum length");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(point_count_we) |-> $stable(pc_q))
		else $error("point count changed without a write");

endmodule

[rtl/altl_ctrl.sv]
module altl_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  altl_pkg::sts_t sts,
	output altl_pkg::cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE    = 14'h0001,
		S_SQ0     = 14'h0002,
		S_SQ1     = 14'h0004,
		S_SQ2     = 14'h0008,
		S_SQGO    = 14'h0010,
		S_SQRT    = 14'h0020,
		S_LFIN    = 14'h0040,
		S_QRD     = 14'h0080,
		S_QCMP    = 14'h0100,
		S_DIVF_GO = 14'h0200,
		S_DIVF    = 14'h0400,
		S_DIVK_GO = 14'h0800,
		S_DIVK    = 14'h1000,
		S_QFIN    = 14'h2000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = sts.req_query ? S_QRD : S_SQ0;
				end
			end
			// squared distance, one axis per cycle
			S_SQ0: begin
				if (sts.idx_zero) begin
					state_d = S_LFIN;
				end else begin
					cmd.sq_en  = 1'b1;
					cmd.sq_sel = altl_pkg::AXIS_X;
					state_d    = S_SQ1;
				end
			end
			S_SQ1: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_sel = altl_pkg::AXIS_Y;
				state_d    = S_SQ2;
			end
			S_SQ2: begin
				cmd.sq_en  = 1'b1;
				cmd.sq_sel = altl_pkg::AXIS_Z;
				state_d    = S_SQGO;
			end
			S_SQGO: begin
				if (sts.over) begin
					state_d = S_LFIN;
				end else begin
					cmd.sqrt_start = 1'b1;
					state_d        = S_SQRT;
				end
			end
			S_SQRT: begin
				if (sts.sqrt_done)
					state_d = S_LFIN;
			end
			S_LFIN: begin
				if (sts.out_free) begin
					cmd.load_fin = 1'b1;
					state_d      = S_IDLE;
				end
			end
			// linear search, read then compare
			S_QRD: begin
				state_d = S_QCMP;
			end
			S_QCMP: begin
				if (sts.hit) begin
					if (sts.need_div) begin
						state_d = S_DIVF_GO;
					end else begin
						cmd.frac_zero = 1'b1;
						state_d       = S_DIVK_GO;
					end
				end else if (sts.last) begin
					cmd.past_end = 1'b1;
					state_d      = S_QFIN;
				end else begin
					cmd.scan_step = 1'b1;
					state_d       = S_QRD;
				end
			end
			S_DIVF_GO: begin
				cmd.div_frac_start = 1'b1;
				state_d            = S_DIVF;
			end
			S_DIVF: begin
				if (sts.div_done) begin
					cmd.frac_take = 1'b1;
					state_d       = S_DIVK_GO;
				end
			end
			S_DIVK_GO: begin
				cmd.div_key_start = 1'b1;
				state_d           = S_DIVK;
			end
			S_DIVK: begin
				if (sts.div_done) begin
					cmd.key_take = 1'b1;
					state_d      = S_QFIN;
				end
			end
			S_QFIN: begin
				if (sts.out_free) begin
					cmd.query_fin = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = state_q == S_IDLE;

	a_sqrt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sqrt_start |-> !sts.idx_zero && !sts.over)
		else $error("square root started on a restart or overflow");

	a_capture_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> state_q != S_IDLE)
		else $error("captured item left no work");

	a_one_start: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.div_frac_start && cmd.div_key_start))
		else $error("two divider starts at once");

endmodule

[rtl/arc_length_table_lookup.sv]
// Cumulative arc length table with length-to-factor lookup. A load beat (req_type 0)
// adds the distance from the last loaded point to the running length, saturating
// at 0xFFFFFFFF, and stores it at point_index; point_index 0 restarts at zero. A
// query beat (req_type 1) finds the first of point_count stored lengths at or above
// query_length and returns (key + fraction) / point_count in Q1.16, or 1.0 past the
// end. One item is processed at a time. A load at point_index 0 skips the distance, a
// load whose squared distance overflows saturates without a root, and any other load
// waits for the 32-step square root unit. A query reads then compares each table
// entry scanned (one memory read port), then runs one 48-step division when the
// fraction is zero or two otherwise, and none past the end. The result register
// frees the input side as soon as a result is written. Reading a table entry that
// was never loaded gives an undefined factor.
module arc_length_table_lookup #(
	parameter int MAX_POINTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               point_count_we,
	input  logic [8:0]         point_count,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [7:0]         point_index,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [31:0]        query_length,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               resp_type,
	output logic [31:0]        point_length,
	output logic [31:0]        total_length,
	output logic [16:0]        factor,
	output logic               length_saturated
);

	altl_pkg::cmd_t cmd;
	altl_pkg::sts_t sts;

	altl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	altl_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.point_count_we   (point_count_we),
		.point_count      (point_count),
		.req_type         (req_type),
		.point_index      (point_index),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.query_length     (query_length),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.resp_type        (resp_type),
		.point_length     (point_length),
		.total_length     (total_length),
		.factor           (factor),
		.length_saturated (length_saturated)
	);

endmodule
